@@ design/scalar_mult_mod_group_order_unit_defines.svh @@
// Assertion macros shared by the checker.
`ifndef SCALAR_MULT_MOD_GROUP_ORDER_UNIT_DEFINES_SVH
`define SCALAR_MULT_MOD_GROUP_ORDER_UNIT_DEFINES_SVH

// Same-cycle implication on the rising clock edge.
`define SCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on the rising clock edge.
`define SCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/scm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package scm_pkg;

    localparam int WORD_W     = 64;
    localparam int PROD_W     = 512;
    localparam int CHUNK_W    = 32;
    localparam int C_CHUNKS   = 4;
    localparam int C_BITS     = 125;
    localparam int FOLD_SHIFT = 252;
    localparam int L_BITS     = 253;

    // group order l = 2^252 + c
    localparam logic [L_BITS-1:0] ORDER_L =
        253'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3ed;
    // c, padded to whole 32-bit chunks
    localparam logic [C_CHUNKS*CHUNK_W-1:0] FOLD_C =
        128'h14def9dea2f79cd65812631a5cf5d3ed;

    typedef enum logic {
        OP_MULT   = 1'b0,
        OP_REDUCE = 1'b1
    } t_op;

    typedef struct packed {
        logic              operation;
        logic [WORD_W-1:0] a_word0;
        logic [WORD_W-1:0] a_word1;
        logic [WORD_W-1:0] a_word2;
        logic [WORD_W-1:0] a_word3;
        logic [WORD_W-1:0] b_word0;
        logic [WORD_W-1:0] b_word1;
        logic [WORD_W-1:0] b_word2;
        logic [WORD_W-1:0] b_word3;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] r_word0;
        logic [WORD_W-1:0] r_word1;
        logic [WORD_W-1:0] r_word2;
        logic [60:0]       r_word3;
        logic              a_out_of_range;
    } t_out;

    // Signed width of lo -/+ h*c for a signed input of width iw.
    function automatic int fold_out_w(input int iw);
        int mw;
        mw = iw - FOLD_SHIFT + C_BITS;
        return ((mw > FOLD_SHIFT) ? mw : FOLD_SHIFT) + 2;
    endfunction

endpackage
`default_nettype wire

@@ design/scm_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scm_mul import scm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PROD_W-1:0] o_prod,
    output logic              o_flag
);

    localparam int NS    = 3;
    localparam int NL    = 8;
    localparam int NPP   = NL * NL;
    localparam int COL_W = CHUNK_W + 4;
    localparam int VEC_W = PROD_W + 2 * CHUNK_W;

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    logic [4*WORD_W-1:0] a_val;
    logic [4*WORD_W-1:0] b_val;

    logic [2*CHUNK_W-1:0] r_pp [NPP];
    logic                 r_flag0;
    logic [VEC_W-1:0]     r_e;
    logic [VEC_W-1:0]     r_o;
    logic                 r_flag1;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_flag2;

    logic [VEC_W-1:0] n_e;
    logic [VEC_W-1:0] n_o;
    logic [VEC_W-1:0] n_sum;

    // advance a stage when it is empty or its successor advances
    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // a reduction is a multiplication by one
    assign a_val = {i_data.a_word3, i_data.a_word2, i_data.a_word1, i_data.a_word0};
    assign b_val = (i_data.operation == OP_REDUCE) ? 256'd1 :
                   {i_data.b_word3, i_data.b_word2, i_data.b_word1, i_data.b_word0};

    // partial products of 32-bit limbs
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    r_pp[i*NL+j] <= a_val[CHUNK_W*i +: CHUNK_W] * b_val[CHUNK_W*j +: CHUNK_W];
                end
            end
            r_flag0 <= (a_val >= {3'b000, ORDER_L});
        end
    end

    // column sums, even and odd columns in separate vectors
    always_comb begin
        logic [COL_W-1:0] acc;
        n_e = '0;
        n_o = '0;
        for (int k = 0; k < 2 * NL; k++) begin
            acc = '0;
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    if (i + j == k)
                        acc = acc + {4'b0000, r_pp[i*NL+j][CHUNK_W-1:0]};
                    if (i + j + 1 == k)
                        acc = acc + {4'b0000, r_pp[i*NL+j][2*CHUNK_W-1:CHUNK_W]};
                end
            end
            if (k % 2 == 0) n_e[CHUNK_W*k +: COL_W] = acc;
            else            n_o[CHUNK_W*k +: COL_W] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_e     <= n_e;
            r_o     <= n_o;
            r_flag1 <= r_flag0;
        end
    end

    // final carry propagation
    assign n_sum = r_e + r_o;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_prod  <= n_sum[PROD_W-1:0];
            r_flag2 <= r_flag1;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_prod  = r_prod;
    assign o_flag  = r_flag2;

endmodule
`default_nettype wire

@@ design/scm_fold.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scm_fold import scm_pkg::*; #(
    parameter int IW = PROD_W + 1,
    parameter int OW = fold_out_w(IW)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [IW-1:0] i_x,
    input  logic                 i_flag,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [OW-1:0] o_y,
    output logic                 o_flag
);

    localparam int NS    = 5;
    localparam int MW    = IW - FOLD_SHIFT;
    localparam int NCH   = (MW + CHUNK_W - 1) / CHUNK_W;
    localparam int NP    = NCH * C_CHUNKS;
    localparam int NCOL  = NCH + C_CHUNKS;
    localparam int COL_W = CHUNK_W + 4;
    localparam int VW0   = CHUNK_W * (NCOL + 1);
    localparam int VW    = (VW0 > OW) ? VW0 : OW;

    logic [NS-1:0] r_vld;
    logic [NS:0]   rdy;

    logic [MW-1:0]          h_bits;
    logic [MW-1:0]          h_mag;
    logic [NCH*CHUNK_W-1:0] n_mag;

    logic [FOLD_SHIFT-1:0]  r_lo0, r_lo1, r_lo2, r_lo3;
    logic                   r_s0, r_s1, r_s2, r_s3;
    logic                   r_flag0, r_flag1, r_flag2, r_flag3, r_flag4;
    logic [NCH*CHUNK_W-1:0] r_mag0;
    logic [2*CHUNK_W-1:0]   r_pp [NP];
    logic [VW-1:0]          r_e;
    logic [VW-1:0]          r_o;
    logic [VW-1:0]          r_m;
    logic signed [OW-1:0]   r_y;

    logic [VW-1:0]        n_e;
    logic [VW-1:0]        n_o;
    logic signed [OW-1:0] lo_ext;
    logic signed [OW-1:0] m_ext;

    always_comb begin
        rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // split x = h * 2^252 + lo, take sign and magnitude of h
    assign h_bits = i_x[IW-1:FOLD_SHIFT];
    assign h_mag  = h_bits[MW-1] ? (~h_bits + 1'b1) : h_bits;

    always_comb begin
        n_mag = '0;
        n_mag[MW-1:0] = h_mag;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_lo0   <= i_x[FOLD_SHIFT-1:0];
            r_s0    <= h_bits[MW-1];
            r_mag0  <= n_mag;
            r_flag0 <= i_flag;
        end
    end

    // partial products |h| * c
    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            for (int i = 0; i < NCH; i++) begin
                for (int j = 0; j < C_CHUNKS; j++) begin
                    r_pp[i*C_CHUNKS+j] <= r_mag0[CHUNK_W*i +: CHUNK_W] *
                                          FOLD_C[CHUNK_W*j +: CHUNK_W];
                end
            end
            r_lo1   <= r_lo0;
            r_s1    <= r_s0;
            r_flag1 <= r_flag0;
        end
    end

    // column sums
    always_comb begin
        logic [COL_W-1:0] acc;
        n_e = '0;
        n_o = '0;
        for (int k = 0; k < NCOL; k++) begin
            acc = '0;
            for (int i = 0; i < NCH; i++) begin
                for (int j = 0; j < C_CHUNKS; j++) begin
                    if (i + j == k)
                        acc = acc + {4'b0000, r_pp[i*C_CHUNKS+j][CHUNK_W-1:0]};
                    if (i + j + 1 == k)
                        acc = acc + {4'b0000, r_pp[i*C_CHUNKS+j][2*CHUNK_W-1:CHUNK_W]};
                end
            end
            if (k % 2 == 0) n_e[CHUNK_W*k +: COL_W] = acc;
            else            n_o[CHUNK_W*k +: COL_W] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_e     <= n_e;
            r_o     <= n_o;
            r_lo2   <= r_lo1;
            r_s2    <= r_s1;
            r_flag2 <= r_flag1;
        end
    end

    // carry propagation of |h| * c
    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_m     <= r_e + r_o;
            r_lo3   <= r_lo2;
            r_s3    <= r_s2;
            r_flag3 <= r_flag2;
        end
    end

    // y = lo - h * c
    assign lo_ext = {{(OW - FOLD_SHIFT){1'b0}}, r_lo3};
    assign m_ext  = r_m[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_y     <= r_s3 ? (lo_ext + m_ext) : (lo_ext - m_ext);
            r_flag4 <= r_flag3;
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_y     = r_y;
    assign o_flag  = r_flag4;

endmodule
`default_nettype wire

@@ design/scm_canon.sv @@
`timescale 1ns / 1ps
`default_nettype none
module scm_canon import scm_pkg::*; #(
    parameter int IW = L_BITS + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [IW-1:0] i_y,
    input  logic                 i_flag,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out                 o_data
);

    logic        r_vld;
    logic        rdy;
    t_out        r_out;

    logic signed [IW:0] yx;
    logic signed [IW:0] lx;
    logic signed [IW:0] y_add;
    logic signed [IW:0] y_sub;
    logic signed [IW:0] n_res;

    assign rdy = ~r_vld | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (rdy) begin
            r_vld <= i_valid;
        end
    end

    // pick y + l, y - l or y, whichever lies in 0 to l-1
    always_comb begin
        yx    = {i_y[IW-1], i_y};
        lx    = '0;
        lx[L_BITS-1:0] = ORDER_L;
        y_add = yx + lx;
        y_sub = yx - lx;
        if (yx[IW])       n_res = y_add;
        else if (!y_sub[IW]) n_res = y_sub;
        else              n_res = yx;
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (rdy) begin
            r_out.r_word0        <= n_res[63:0];
            r_out.r_word1        <= n_res[127:64];
            r_out.r_word2        <= n_res[191:128];
            r_out.r_word3        <= n_res[252:192];
            r_out.a_out_of_range <= i_flag;
        end
    end

    assign o_ready = rdy;
    assign o_valid = r_vld;
    assign o_data  = r_out;

endmodule
`default_nettype wire

@@ design/scalar_mult_mod_group_order_unit.sv @@
// Channel  Valid    Ready    Payload  Item
// input    i_valid  o_ready  i_data   operation and operands a, b
// output   o_valid  i_ready  o_data   canonical result and range flag
//
// One item enters per cycle while o_ready is high; stages: 3 multiply, 3 x 5 fold, 1 output.
// The 32x32 partial-product arrays, in the multiplier and in each fold, are all pipelined.
// Reset (i_rst_n low at a clock edge) empties every stage.
// A stall on the output holds each full stage; empty stages still fill, so
// input keeps flowing until the pipe is full.
`timescale 1ns / 1ps
`default_nettype none
module scalar_mult_mod_group_order_unit import scm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int R1_IN = PROD_W + 1;
    localparam int R1_W  = fold_out_w(R1_IN);
    localparam int R2_W  = fold_out_w(R1_W);
    localparam int R3_W  = fold_out_w(R2_W);

    logic              mul_vld, mul_rdy, mul_flag;
    logic [PROD_W-1:0] mul_prod;
    logic signed [R1_IN-1:0] prod_x;

    logic                   f1_vld, f1_rdy, f1_flag;
    logic signed [R1_W-1:0] f1_y;
    logic                   f2_vld, f2_rdy, f2_flag;
    logic signed [R2_W-1:0] f2_y;
    logic                   f3_vld, f3_rdy, f3_flag;
    logic signed [R3_W-1:0] f3_y;

    // full product, or a itself for a reduction
    scm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (mul_vld),
        .i_ready (mul_rdy),
        .o_prod  (mul_prod),
        .o_flag  (mul_flag)
    );

    assign prod_x = {1'b0, mul_prod};

    // three folds by 2^252 = -c (mod l)
    scm_fold #(.IW(R1_IN), .OW(R1_W)) u_fold1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_vld),
        .o_ready (mul_rdy),
        .i_x     (prod_x),
        .i_flag  (mul_flag),
        .o_valid (f1_vld),
        .i_ready (f1_rdy),
        .o_y     (f1_y),
        .o_flag  (f1_flag)
    );

    scm_fold #(.IW(R1_W), .OW(R2_W)) u_fold2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f1_vld),
        .o_ready (f1_rdy),
        .i_x     (f1_y),
        .i_flag  (f1_flag),
        .o_valid (f2_vld),
        .i_ready (f2_rdy),
        .o_y     (f2_y),
        .o_flag  (f2_flag)
    );

    scm_fold #(.IW(R2_W), .OW(R3_W)) u_fold3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f2_vld),
        .o_ready (f2_rdy),
        .i_x     (f2_y),
        .i_flag  (f2_flag),
        .o_valid (f3_vld),
        .i_ready (f3_rdy),
        .o_y     (f3_y),
        .o_flag  (f3_flag)
    );

    // bring into 0 to l-1 and register the output
    scm_canon #(.IW(R3_W)) u_canon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f3_vld),
        .o_ready (f3_rdy),
        .i_y     (f3_y),
        .i_flag  (f3_flag),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

@@ design/scm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_mult_mod_group_order_unit_defines.svh"
module scm_checker import scm_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    // hold a stalled item
    `SCM_ASSERT_NXT(a_hold_valid, i_rst_n && o_valid && !i_ready, o_valid, "output item dropped while stalled")
    `SCM_ASSERT_NXT(a_hold_data, i_rst_n && o_valid && !i_ready, $stable(o_data), "output item changed while stalled")

    // drop everything on reset
    `SCM_ASSERT_NXT(a_reset_empty, !i_rst_n, !o_valid, "output valid right after reset")

    // result below l
    `SCM_ASSERT_IMP(a_canonical, i_rst_n && o_valid && o_data.r_word3[60], o_data.r_word3[59:0] == 60'd0 && o_data.r_word2 == 64'd0 && (o_data.r_word1 < 64'h14def9dea2f79cd6 || (o_data.r_word1 == 64'h14def9dea2f79cd6 && o_data.r_word0 < 64'h5812631a5cf5d3ed)), "result not below the group order")

endmodule

bind scalar_mult_mod_group_order_unit scm_checker u_chk (.*);
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import scm_pkg::*;

    localparam int LATENCY  = 19;
    localparam int WD_LIMIT = 2000;
    localparam logic [511:0] GROUP_L = {259'd0, ORDER_L};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    scalar_mult_mod_group_order_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    t_in  pending_items[$];
    t_out expected_results[$];
    int   fail_count = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_phase = 0;

    // Compute the canonical result and range flag for one item.
    function automatic t_out predict_scalar(input t_in item);
        logic [511:0] a_val, b_val, num;
        t_out res;
        a_val = {256'd0, item.a_word3, item.a_word2, item.a_word1, item.a_word0};
        b_val = {256'd0, item.b_word3, item.b_word2, item.b_word1, item.b_word0};
        num = (item.operation == OP_MULT) ? a_val * b_val : a_val;
        num = num % GROUP_L;
        res.r_word0 = num[63:0];
        res.r_word1 = num[127:64];
        res.r_word2 = num[191:128];
        res.r_word3 = num[252:192];
        res.a_out_of_range = (a_val >= GROUP_L);
        return res;
    endfunction

    function automatic t_in make_item(input logic op, input logic [255:0] a,
                                      input logic [255:0] b);
        t_in item;
        item.operation = op;
        {item.a_word3, item.a_word2, item.a_word1, item.a_word0} = a;
        {item.b_word3, item.b_word2, item.b_word1, item.b_word0} = b;
        return item;
    endfunction

    function automatic logic [255:0] rand_256();
        logic [255:0] v;
        for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    // Pick operands near interesting values: zero, l, all ones, random.
    function automatic logic [255:0] rand_operand();
        logic [255:0] base;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: base = 256'($urandom_range(0, 3));
            1: base = {3'd0, ORDER_L} - 256'($urandom_range(0, 3));
            2: base = {3'd0, ORDER_L} + 256'($urandom_range(0, 3));
            3: base = '1 - 256'($urandom_range(0, 3));
            4: base = rand_256() >> $urandom_range(0, 255);
            default: base = rand_256();
        endcase
        return base;
    endfunction

    // Fill the queue: directed corners, then random items.
    initial begin
        logic [255:0] lval, ones;
        lval = {3'd0, ORDER_L};
        ones = '1;
        for (int op = 0; op < 2; op++) begin
            pending_items.push_back(make_item(1'(op), '0, '0));
            pending_items.push_back(make_item(1'(op), 256'd1, 256'd1));
            pending_items.push_back(make_item(1'(op), lval - 1, lval - 1));
            pending_items.push_back(make_item(1'(op), lval, 256'd5));
            pending_items.push_back(make_item(1'(op), lval + 1, lval));
            pending_items.push_back(make_item(1'(op), ones, ones));
            pending_items.push_back(make_item(1'(op), lval << 3, ones));
            pending_items.push_back(make_item(1'(op), 256'd2, lval - 1));
        end
        pending_items.push_back(make_item(OP_REDUCE, lval - 1, ones));
        for (int n = 0; n < 1500; n++)
            pending_items.push_back(make_item(1'($urandom_range(0, 1)),
                                              rand_operand(), rand_operand()));
        stim_done = 1'b1;
    end

    // Drive items in bursts with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Stall the output on a rotating pattern.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9:8] == 2'd0)
            i_ready <= 1'b1;
        else if (stall_phase[9:8] == 2'd1)
            i_ready <= stall_phase[2:0] != 3'd5;
        else
            i_ready <= ($urandom_range(0, 3) != 0);
    end

    // Record expectations and check results.
    always @(posedge i_clk) begin
        t_out exp_res;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                expected_results.push_back(predict_scalar(i_data));
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, o_data);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_data.r_word0 !== exp_res.r_word0 ||
                        o_data.r_word1 !== exp_res.r_word1 ||
                        o_data.r_word2 !== exp_res.r_word2 ||
                        o_data.r_word3 !== exp_res.r_word3 ||
                        o_data.a_out_of_range !== exp_res.a_out_of_range) begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, exp_res, o_data);
                        fail_count++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset, then wait for drain or watchdog.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_cycles >= WD_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (stim_done && pending_items.size() == 0 && !i_valid &&
                expected_results.size() == 0)
                break;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
